// ===== design/tgfe_pkg.sv =====
// Shared types, codes and font-table functions for the text glyph fetch and expand block.
package tgfe_pkg;

   // Input item and result item as they travel on the ports
   typedef struct packed {
      logic       opcode;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] fetch_addr;
      logic [7:0]  fetch_len;
      logic [15:0] pixel_x;
      logic [15:0] pixel_y;
      logic [15:0] pixel_color;
      logic        last;
   } rsp_type;

   // Work passed from the front end to the back end
   typedef struct packed {
      logic        is_pix;
      logic        wide;
      logic [31:0] index;
      logic [7:0]  glyph_bits;
      logic [15:0] x0;
      logic [15:0] y;
   } cmd_type;

   // Configuration as seen by the front and back ends
   typedef struct packed {
      logic [15:0] origin_x;
      logic [15:0] origin_y;
      logic [15:0] fg_color;
      logic [15:0] off_color;
      logic [1:0]  size_code;
      logic        origin_load;
      logic [15:0] origin_value;
   } cfg_type;

   // Opcodes and result kinds
   localparam logic OP_TEXT    = 1'b0;
   localparam logic OP_GLYPH   = 1'b1;
   localparam logic KIND_FETCH = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   // Register indexes
   localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
   localparam logic [2:0] REG_FG_COLOR  = 3'd2;
   localparam logic [2:0] REG_BG_COLOR  = 3'd3;
   localparam logic [2:0] REG_SIZE_CODE = 3'd4;

   // Size codes
   localparam logic [1:0] SIZE_16 = 2'd0;
   localparam logic [1:0] SIZE_24 = 2'd1;

   // GB2312 code layout
   localparam logic [8:0]  LEAD_MIN  = 9'h0A1;
   localparam logic [13:0] ROW_CHARS = 14'd94;

   localparam logic [15:0] BG_RESET = 16'hFFFF;

   // Glyph height in rows; code three saturates to 32
   function automatic logic [5:0] glyph_size(input logic [1:0] code);
      logic [5:0] s;
      unique case (code)
         SIZE_16: s = 6'd16;
         SIZE_24: s = 6'd24;
         default: s = 6'd32;
      endcase
      return s;
   endfunction

   // Bitmap bytes per glyph row
   function automatic logic [2:0] row_bytes(input logic [1:0] code, input logic wide);
      logic [2:0] r;
      unique case (code)
         SIZE_16: r = wide ? 3'd2 : 3'd1;
         SIZE_24: r = wide ? 3'd3 : 3'd2;
         default: r = wide ? 3'd4 : 3'd2;
      endcase
      return r;
   endfunction

   // Bitmap length in bytes
   function automatic logic [7:0] glyph_len(input logic [1:0] code, input logic wide);
      logic [7:0] n;
      unique case (code)
         SIZE_16: n = wide ? 8'd32 : 8'd16;
         SIZE_24: n = wide ? 8'd72 : 8'd48;
         default: n = wide ? 8'd128 : 8'd64;
      endcase
      return n;
   endfunction

   // Font flash base address of each glyph table
   function automatic logic [31:0] glyph_base(input logic [1:0] code, input logic wide);
      logic [31:0] a;
      unique case (code)
         SIZE_16: a = wide ? 32'h0000_4012 : 32'h0000_0000;
         SIZE_24: a = wide ? 32'h0004_3E58 : 32'h0000_0806;
         default: a = wide ? 32'h000D_3A6E : 32'h0000_200C;
      endcase
      return a;
   endfunction

endpackage

// ===== design/tgfe_front.sv =====
// Front end: decodes text and glyph bytes, tracks cursor and glyph position, queues work.
module tgfe_front (
   input  logic             clock,
   input  logic             reset,
   input  tgfe_pkg::cfg_type cfg,
   input  logic             accept,
   input  tgfe_pkg::req_type item,
   output logic             cmd_push,
   output tgfe_pkg::cmd_type cmd
);
   import tgfe_pkg::*;

   logic [15:0] cursor_ff, cursor_in;
   logic        lead_pending_ff, lead_pending_in;
   logic [7:0]  lead_byte_ff, lead_byte_in;
   logic        active_ff, active_in;
   logic        wide_ff, wide_in;
   logic [15:0] gorigin_ff, gorigin_in;
   logic [5:0]  row_ff, row_in;
   logic [1:0]  bir_ff, bir_in;

   logic [6:0]  lead_off;
   logic [8:0]  trail_off;
   logic [31:0] wide_index;
   logic [5:0]  size;
   logic [6:0]  next_row;
   logic [2:0]  next_bir;
   logic        issue;
   logic        issue_wide;

   // Wide glyph index: lead offset is 0..94, trail offset may be negative and wraps
   assign lead_off   = 7'({1'b0, lead_byte_ff} - LEAD_MIN);
   assign trail_off  = {1'b0, item.data_byte} - LEAD_MIN;
   assign wide_index = 32'(14'(lead_off) * ROW_CHARS) + {{23{trail_off[8]}}, trail_off};
   assign size       = glyph_size(cfg.size_code);

   always_comb begin
      cursor_in       = cursor_ff;
      lead_pending_in = lead_pending_ff;
      lead_byte_in    = lead_byte_ff;
      active_in       = active_ff;
      wide_in         = wide_ff;
      gorigin_in      = gorigin_ff;
      row_in          = row_ff;
      bir_in          = bir_ff;
      cmd_push        = 1'b0;
      cmd             = '0;
      issue           = 1'b0;
      issue_wide      = 1'b0;
      next_bir        = 3'({1'b0, bir_ff} + 3'd1);
      next_row        = {1'b0, row_ff};

      if (accept && item.opcode == OP_TEXT) begin
         // Classify the text byte
         priority if (lead_pending_ff) begin
            lead_pending_in = 1'b0;
            issue           = 1'b1;
            issue_wide      = 1'b1;
            cmd.index       = wide_index;
         end else if (item.data_byte == 8'd0) begin
            cursor_in    = cfg.origin_x;
            lead_byte_in = 8'd0;
         end else if ({1'b0, item.data_byte} >= LEAD_MIN) begin
            lead_pending_in = 1'b1;
            lead_byte_in    = item.data_byte;
         end else begin
            issue     = 1'b1;
            cmd.index = {24'd0, item.data_byte};
         end
      end else if (accept && active_ff) begin
         // Queue one glyph byte and advance the row and byte counters
         cmd_push       = 1'b1;
         cmd.is_pix     = 1'b1;
         cmd.glyph_bits = item.data_byte;
         cmd.x0         = gorigin_ff + {11'd0, bir_ff, 3'd0};
         cmd.y          = cfg.origin_y + {10'd0, row_ff};
         if (next_bir >= row_bytes(cfg.size_code, wide_ff)) begin
            next_bir = 3'd0;
            next_row = next_row + 7'd1;
         end
         if (next_row >= {1'b0, size}) begin
            active_in = 1'b0;
            next_row  = 7'd0;
            next_bir  = 3'd0;
         end
         row_in = next_row[5:0];
         bir_in = next_bir[1:0];
      end else if (cfg.origin_load) begin
         cursor_in = cfg.origin_value;
      end

      // Start a new glyph and move the cursor by its width
      if (issue) begin
         cmd_push   = 1'b1;
         cmd.is_pix = 1'b0;
         cmd.wide   = issue_wide;
         active_in  = 1'b1;
         wide_in    = issue_wide;
         gorigin_in = cursor_ff;
         row_in     = 6'd0;
         bir_in     = 2'd0;
         cursor_in  = cursor_ff + {10'd0, issue_wide ? size : {1'b0, size[5:1]}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff       <= '0;
         lead_pending_ff <= 1'b0;
         lead_byte_ff    <= '0;
         active_ff       <= 1'b0;
         wide_ff         <= 1'b0;
         gorigin_ff      <= '0;
         row_ff          <= '0;
         bir_ff          <= '0;
      end else begin
         cursor_ff       <= cursor_in;
         lead_pending_ff <= lead_pending_in;
         lead_byte_ff    <= lead_byte_in;
         active_ff       <= active_in;
         wide_ff         <= wide_in;
         gorigin_ff      <= gorigin_in;
         row_ff          <= row_in;
         bir_ff          <= bir_in;
      end
   end

endmodule

// ===== design/tgfe_fifo.sv =====
// Short command queue between the front and back ends.
module tgfe_fifo #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tgfe_pkg::cmd_type push_cmd,
   input  logic             pop,
   output tgfe_pkg::cmd_type head,
   output logic             empty,
   output logic             full
);
   import tgfe_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type        entries_ff [DEPTH];
   logic [PW-1:0]  wr_ff, wr_in;
   logic [PW-1:0]  rd_ff, rd_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_push, do_pop;

   assign empty   = (count_ff == CW'(0));
   assign full    = (count_ff == CW'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entries_ff[rd_ff];

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

// ===== design/tgfe_back.sv =====
// Back end: turns queued commands into fetch requests and pixel beats.
module tgfe_back (
   input  logic             clock,
   input  logic             reset,
   input  tgfe_pkg::cfg_type cfg,
   input  tgfe_pkg::cmd_type head,
   input  logic             head_valid,
   output logic             head_pop,
   input  logic             pop,
   output logic             empty,
   output tgfe_pkg::rsp_type rsp
);
   import tgfe_pkg::*;

   rsp_type     rsp_ff, rsp_in;
   logic        valid_ff, valid_in;
   logic [2:0]  bit_ff, bit_in;
   logic        load;
   logic [7:0]  len;
   logic [31:0] offset;

   assign empty  = !valid_ff;
   assign rsp    = rsp_ff;
   assign load   = head_valid && (!valid_ff || pop);
   assign len    = glyph_len(cfg.size_code, head.wide);
   assign offset = head.index * {24'd0, len};

   // Build the next beat from the queue head
   always_comb begin
      rsp_in   = rsp_ff;
      bit_in   = bit_ff;
      head_pop = 1'b0;
      valid_in = valid_ff && !pop;
      if (load) begin
         valid_in = 1'b1;
         rsp_in   = '0;
         if (head.is_pix) begin
            rsp_in.kind        = KIND_PIXEL;
            rsp_in.pixel_x     = head.x0 + {13'd0, bit_ff};
            rsp_in.pixel_y     = head.y;
            rsp_in.pixel_color = head.glyph_bits[3'd7 - bit_ff] ? cfg.fg_color : cfg.off_color;
            rsp_in.last        = (bit_ff == 3'd7);
            head_pop           = (bit_ff == 3'd7);
            bit_in             = bit_ff + 3'd1;
         end else begin
            rsp_in.kind       = KIND_FETCH;
            rsp_in.fetch_addr = glyph_base(cfg.size_code, head.wide) + offset;
            rsp_in.fetch_len  = len;
            rsp_in.last       = 1'b1;
            head_pop          = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         bit_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         bit_ff   <= bit_in;
      end
   end

   // Hold the result payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

// ===== design/text_glyph_fetch_and_expand.sv =====
// Top level: configuration registers, front end, command queue and back end.
//
//   channel   direction   handshake                     payload
//   request   in          push / full                   req_item (opcode, data_byte)
//   result    out         empty / pop                   rsp_item (fetch or pixel beat)
//   config    in/out      psel penable pwrite pready    paddr, pwdata, prdata
//
// The front end takes one byte per cycle while the queue has room. In the back
// end a fetch request is a single beat and a glyph byte expands to one pixel
// beat per bit, one pixel beat per cycle while results are popped, so a glyph
// stream is paced by the result register. Reset is synchronous and needs no
// clearing pass. A stalled pop holds the result register; the queue of
// QUEUE_DEPTH commands absorbs the front end until it fills.
module text_glyph_fetch_and_expand #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  tgfe_pkg::req_type req_item,
   output logic              empty,
   input  logic              pop,
   output tgfe_pkg::rsp_type rsp_item,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import tgfe_pkg::*;

   logic [15:0] origin_x_ff, origin_y_ff, fg_ff, bg_ff;
   logic [1:0]  size_ff;
   logic        csr_write;
   logic [2:0]  csr_index;
   cfg_type     cfg;
   logic        accept;
   logic        fifo_push, fifo_full, fifo_empty, fifo_pop;
   cmd_type     push_cmd, head;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[4:2];

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         fg_ff       <= '0;
         bg_ff       <= BG_RESET;
         size_ff     <= SIZE_16;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_ORIGIN_X:  origin_x_ff <= pwdata[15:0];
            REG_ORIGIN_Y:  origin_y_ff <= pwdata[15:0];
            REG_FG_COLOR:  fg_ff       <= pwdata[15:0];
            REG_BG_COLOR:  bg_ff       <= pwdata[15:0];
            REG_SIZE_CODE: size_ff     <= pwdata[1:0];
            default: ;
         endcase
      end
   end

   // Read back configuration registers
   always_comb begin
      unique case (csr_index)
         REG_ORIGIN_X:  prdata = {16'd0, origin_x_ff};
         REG_ORIGIN_Y:  prdata = {16'd0, origin_y_ff};
         REG_FG_COLOR:  prdata = {16'd0, fg_ff};
         REG_BG_COLOR:  prdata = {16'd0, bg_ff};
         REG_SIZE_CODE: prdata = {30'd0, size_ff};
         default:       prdata = '0;
      endcase
   end

   always_comb begin
      cfg.origin_x     = origin_x_ff;
      cfg.origin_y     = origin_y_ff;
      cfg.fg_color     = fg_ff;
      cfg.off_color    = bg_ff;
      cfg.size_code    = size_ff;
      cfg.origin_load  = csr_write && (csr_index == REG_ORIGIN_X);
      cfg.origin_value = pwdata[15:0];
   end

   assign full   = fifo_full;
   assign accept = push && !fifo_full;

   tgfe_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .accept   (accept),
      .item     (req_item),
      .cmd_push (fifo_push),
      .cmd      (push_cmd)
   );

   tgfe_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (fifo_push),
      .push_cmd (push_cmd),
      .pop      (fifo_pop),
      .head     (head),
      .empty    (fifo_empty),
      .full     (fifo_full)
   );

   tgfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head       (head),
      .head_valid (!fifo_empty),
      .head_pop   (fifo_pop),
      .pop        (pop),
      .empty      (empty),
      .rsp        (rsp_item)
   );

   // The front end never queues work into a full queue
   assert property (@(posedge clock) disable iff (reset) fifo_push |-> !fifo_full)
      else $error("command queued while queue full");

   // A fetch request beat is always marked as a final beat
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.kind == KIND_FETCH) |-> rsp_item.last)
      else $error("fetch beat without last");

   // Pixels of one byte follow each other with no gap, one column apart
   assert property (@(posedge clock) disable iff (reset)
      (pop && !empty && rsp_item.kind == KIND_PIXEL && !rsp_item.last) |=>
      (!empty && rsp_item.kind == KIND_PIXEL &&
       rsp_item.pixel_x == $past(rsp_item.pixel_x) + 16'd1))
      else $error("pixel run broken");

endmodule
